@@ src/cdq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdq_pkg
// Types and codes shared by the deque cell row and its control.
// ----------------------------------------------------------------------------
package cdq_pkg;

  localparam int unsigned WORD_W = 32;

  typedef enum logic [1:0] {
    CMD_PUSH_REAR  = 2'd0,
    CMD_PUSH_FRONT = 2'd1,
    CMD_POP_FRONT  = 2'd2,
    CMD_POP_REAR   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // per-row operation, seen from the row's own near end (cell 0)
  typedef enum logic [2:0] {
    OP_HOLD      = 3'd0,
    OP_PUSH_NEAR = 3'd1,
    OP_POP_NEAR  = 3'd2,
    OP_PUSH_FAR  = 3'd3,
    OP_POP_FAR   = 3'd4
  } op_e;

  typedef struct packed {
    logic [1:0]               command;
    logic signed [WORD_W-1:0] push_value;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] popped_value;
    logic [1:0]               status;
    logic [3:0]               occupancy;
    logic                     is_empty;
    logic                     is_full;
  } out_t;

  typedef struct packed {
    op_e               op;
    logic [WORD_W-1:0] word;
  } ctl_t;

  typedef struct packed {
    logic              vld;
    logic [WORD_W-1:0] data;
  } link_t;

endpackage

@@ src/cdq_cell.sv @@
// ----------------------------------------------------------------------------
// cdq_cell
// One storage cell of a row: a word and its valid bit, moved from or to
// its neighbors according to the row operation.
// ----------------------------------------------------------------------------
module cdq_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cdq_pkg::ctl_t  ctl_i,
  input  cdq_pkg::link_t left_i,
  input  cdq_pkg::link_t right_i,
  output cdq_pkg::link_t state_o
);

  logic                       vld_q, vld_d;
  logic [cdq_pkg::WORD_W-1:0] data_q, data_d;

  always_comb begin
    vld_d  = vld_q;
    data_d = data_q;
    case (ctl_i.op)
      cdq_pkg::OP_PUSH_NEAR: begin
        vld_d  = left_i.vld;
        data_d = left_i.data;
      end
      cdq_pkg::OP_POP_NEAR: begin
        vld_d  = right_i.vld;
        data_d = right_i.data;
      end
      cdq_pkg::OP_PUSH_FAR: begin
        // first free cell takes the word
        if (!vld_q && left_i.vld) begin
          vld_d  = 1'b1;
          data_d = ctl_i.word;
        end
      end
      cdq_pkg::OP_POP_FAR: begin
        // last occupied cell lets go
        if (vld_q && !right_i.vld) begin
          vld_d = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign state_o.vld  = vld_q;
  assign state_o.data = data_q;

endmodule

@@ src/cdq_row.sv @@
// ----------------------------------------------------------------------------
// cdq_row
// A row of cells with the near end at cell 0. Pushes and pops at the near
// end shift the whole row; at the far end only the boundary cell changes.
// ----------------------------------------------------------------------------
module cdq_row #(
  parameter int unsigned DEPTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cdq_pkg::ctl_t  ctl_i,
  output cdq_pkg::link_t near_o
);

  cdq_pkg::link_t cell_st [DEPTH];
  cdq_pkg::link_t left_in [DEPTH];
  cdq_pkg::link_t right_in[DEPTH];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_in[i].vld  = 1'b1;
      assign left_in[i].data = ctl_i.word;
    end else begin : g_mid_l
      assign left_in[i] = cell_st[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right_in[i].vld  = 1'b0;
      assign right_in[i].data = '0;
    end else begin : g_mid_r
      assign right_in[i] = cell_st[i+1];
    end

    cdq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctl_i   (ctl_i),
      .left_i  (left_in[i]),
      .right_i (right_in[i]),
      .state_o (cell_st[i])
    );
  end

  assign near_o = cell_st[0];

endmodule

@@ src/circular_deque_unit.sv @@
// ----------------------------------------------------------------------------
// circular_deque_unit
// Double-ended queue of signed words in two rows of cells: one row keeps the
// front at cell 0, the other keeps the rear at cell 0, so both ends read
// from a fixed cell. Full pushes and empty pops are rejected.
// ----------------------------------------------------------------------------
// result: registered, valid in the cycle after its command word is accepted
// throughput: one command per cycle; every cell moves at most one neighbor
//   step per command, and input stalls only while the output register holds
//   a word not yet taken
// reset: count, valid bits and output valid clear at once; cell data has no
//   reset and is read only after a push has written it
module circular_deque_unit #(
  parameter int unsigned DEPTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  cdq_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output cdq_pkg::out_t out_data_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  logic            acc;
  logic [CntW-1:0] count_q, count_d;
  logic            full, empty;
  cdq_pkg::ctl_t   front_ctl, rear_ctl;
  cdq_pkg::link_t  front_near, rear_near;
  cdq_pkg::out_t   res, out_q;
  logic            out_valid_q;
  cdq_pkg::cmd_e   cmd;

  assign in_stall_o = out_valid_q && out_stall_i;
  assign acc        = in_valid_i && !in_stall_o;
  assign full       = (count_q == CntW'(DEPTH));
  assign empty      = (count_q == '0);
  assign cmd        = cdq_pkg::cmd_e'(in_data_i.command);

  always_comb begin
    front_ctl.op   = cdq_pkg::OP_HOLD;
    front_ctl.word = in_data_i.push_value;
    rear_ctl.op    = cdq_pkg::OP_HOLD;
    rear_ctl.word  = in_data_i.push_value;
    count_d        = count_q;
    res            = '0;
    res.status     = cdq_pkg::ST_DONE;
    case (cmd)
      cdq_pkg::CMD_PUSH_REAR: begin
        if (full) begin
          res.status = cdq_pkg::ST_FULL;
        end else begin
          front_ctl.op = cdq_pkg::OP_PUSH_FAR;
          rear_ctl.op  = cdq_pkg::OP_PUSH_NEAR;
          count_d      = count_q + CntW'(1);
        end
      end
      cdq_pkg::CMD_PUSH_FRONT: begin
        if (full) begin
          res.status = cdq_pkg::ST_FULL;
        end else begin
          front_ctl.op = cdq_pkg::OP_PUSH_NEAR;
          rear_ctl.op  = cdq_pkg::OP_PUSH_FAR;
          count_d      = count_q + CntW'(1);
        end
      end
      cdq_pkg::CMD_POP_FRONT: begin
        if (empty) begin
          res.status = cdq_pkg::ST_EMPTY;
        end else begin
          res.popped_value = $signed(front_near.data);
          front_ctl.op     = cdq_pkg::OP_POP_NEAR;
          rear_ctl.op      = cdq_pkg::OP_POP_FAR;
          count_d          = count_q - CntW'(1);
        end
      end
      cdq_pkg::CMD_POP_REAR: begin
        if (empty) begin
          res.status = cdq_pkg::ST_EMPTY;
        end else begin
          res.popped_value = $signed(rear_near.data);
          front_ctl.op     = cdq_pkg::OP_POP_FAR;
          rear_ctl.op      = cdq_pkg::OP_POP_NEAR;
          count_d          = count_q - CntW'(1);
        end
      end
      default: begin
      end
    endcase
    res.occupancy = 4'(count_d);
    res.is_empty  = (count_d == '0);
    res.is_full   = (count_d == CntW'(DEPTH));
    // nothing moves unless the word is taken
    if (!acc) begin
      front_ctl.op = cdq_pkg::OP_HOLD;
      rear_ctl.op  = cdq_pkg::OP_HOLD;
      count_d      = count_q;
    end
  end

  cdq_row #(
    .DEPTH (DEPTH)
  ) u_front_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (front_ctl),
    .near_o (front_near)
  );

  cdq_row #(
    .DEPTH (DEPTH)
  ) u_rear_row (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (rear_ctl),
    .near_o (rear_near)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(DEPTH))
    else $error("occupancy count beyond depth");

  a_rows_agree: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_near.vld == rear_near.vld)
    else $error("front and rear rows disagree on emptiness");

  a_front_vs_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    front_near.vld == (count_q != '0))
    else $error("front cell valid does not match count");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc && (cmd == cdq_pkg::CMD_POP_FRONT || cmd == cdq_pkg::CMD_POP_REAR) && !empty
    |=> count_q == $past(count_q) - CntW'(1))
    else $error("pop did not lower the count");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status == cdq_pkg::ST_FULL |-> out_q.is_full)
    else $error("full rejection reported with queue not full");

endmodule

@@ test/deque_mirror_check.sv @@
// ----------------------------------------------------------------------------
// deque_mirror_check
// Watches both channels of the deque, keeps a mirror of ring, head, tail and
// count, and compares every result word with the mirror's answer in order.
// ----------------------------------------------------------------------------
module deque_mirror_check #(
  parameter int unsigned DEPTH = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_stall_i,
  input  cdq_pkg::in_t  in_data_i,
  input  logic          out_valid_i,
  input  logic          out_stall_i,
  input  cdq_pkg::out_t out_data_i,
  output int unsigned   fail_count_o,
  output int unsigned   pending_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);

  logic [cdq_pkg::WORD_W-1:0] ring [DEPTH];
  int unsigned                head_q;
  int unsigned                tail_q;
  int unsigned                count_q;
  cdq_pkg::out_t              awaited_results[$];

  // applies one command to the mirror and returns the word it should produce
  function automatic cdq_pkg::out_t deque_apply(cdq_pkg::in_t w);
    cdq_pkg::out_t r;
    r        = '0;
    r.status = cdq_pkg::ST_DONE;
    case (w.command)
      cdq_pkg::CMD_PUSH_REAR, cdq_pkg::CMD_PUSH_FRONT: begin
        if (count_q >= DEPTH) begin
          r.status = cdq_pkg::ST_FULL;
        end else if (w.command == cdq_pkg::CMD_PUSH_REAR) begin
          ring[IdxW'(tail_q)] = w.push_value;
          tail_q              = (tail_q + 1) % DEPTH;
          count_q++;
        end else begin
          // head steps back before the write
          head_q              = (head_q + DEPTH - 1) % DEPTH;
          ring[IdxW'(head_q)] = w.push_value;
          count_q++;
        end
      end
      default: begin
        if (count_q == 0) begin
          r.status = cdq_pkg::ST_EMPTY;
        end else if (w.command == cdq_pkg::CMD_POP_FRONT) begin
          r.popped_value = ring[IdxW'(head_q)];
          head_q         = (head_q + 1) % DEPTH;
          count_q--;
        end else begin
          // tail steps back before the read
          tail_q         = (tail_q + DEPTH - 1) % DEPTH;
          r.popped_value = ring[IdxW'(tail_q)];
          count_q--;
        end
      end
    endcase
    r.occupancy = 4'(count_q);
    r.is_empty  = (count_q == 0);
    r.is_full   = (count_q == DEPTH);
    return r;
  endfunction

  task automatic check_field(string field, logic [31:0] want_v, logic [31:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0h got %0h", $time, field, want_v, got_v);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    cdq_pkg::out_t got;
    cdq_pkg::out_t want;
    if (!rst_ni) begin
      head_q       = 0;
      tail_q       = 0;
      count_q      = 0;
      awaited_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // result first: it can only belong to an earlier command
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        if (awaited_results.size() == 0) begin
          $display("%0t: result word with nothing expected, expected none got %p",
                   $time, got);
          fail_count_o++;
        end else begin
          want = awaited_results.pop_front();
          check_field("popped_value", want.popped_value, got.popped_value);
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("occupancy", 32'(want.occupancy), 32'(got.occupancy));
          check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
          check_field("is_full", 32'(want.is_full), 32'(got.is_full));
        end
      end
      if (in_valid_i && !in_stall_i) begin
        awaited_results.push_back(deque_apply(in_data_i));
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

@@ test/tb_circular_deque_unit.sv @@
// ----------------------------------------------------------------------------
// tb_circular_deque_unit
// Drives command words into the deque with random gaps and output stalls:
// a directed pass over extremes, wrap, full and empty rejects, then random
// runs biased toward filling, draining or churning.
// ----------------------------------------------------------------------------
module tb_circular_deque_unit;

  localparam int unsigned DEPTH        = 8;
  localparam int unsigned RANDOM_WORDS = 1850;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_stall_o;
  cdq_pkg::in_t  in_data_i   = '0;
  logic          out_valid_o;
  logic          out_stall_i = 1'b0;
  cdq_pkg::out_t out_data_o;
  int unsigned   fails;
  int unsigned   pending;

  bit          quiet      = 1'b0;
  int unsigned stall_left = 0;
  logic        out_took   = 1'b0;

  circular_deque_unit #(.DEPTH(DEPTH)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  deque_mirror_check #(.DEPTH(DEPTH)) mirror (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_i  (out_data_o),
    .fail_count_o(fails),
    .pending_o   (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned draw_wait();
    return quiet ? 0 : $urandom_range(0, 13);
  endfunction

  // receiver: a fresh stall length after every taken word
  always @(posedge clk_i) begin
    out_took <= out_valid_o && !out_stall_i;
  end

  always @(negedge clk_i) begin
    if (out_took) stall_left = draw_wait();
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_word(cdq_pkg::cmd_e c, logic [cdq_pkg::WORD_W-1:0] v);
    int unsigned  gap;
    cdq_pkg::in_t w;
    gap          = draw_wait();
    w.command    = c;
    w.push_value = v;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  function automatic cdq_pkg::cmd_e pick_command(int unsigned push_pct);
    bit side;
    side = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 99) < push_pct) begin
      return side ? cdq_pkg::CMD_PUSH_FRONT : cdq_pkg::CMD_PUSH_REAR;
    end
    return side ? cdq_pkg::CMD_POP_REAR : cdq_pkg::CMD_POP_FRONT;
  endfunction

  function automatic logic [cdq_pkg::WORD_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0:       return 32'h7fff_ffff;
      1:       return 32'h8000_0000;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int unsigned sent;
    int unsigned span;
    int unsigned push_pct;
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // pops on an empty deque are rejected
    send_word(cdq_pkg::CMD_POP_FRONT, 32'h1234_5678);
    send_word(cdq_pkg::CMD_POP_REAR, 32'hffff_ffff);
    // fill from both ends; the first front push wraps the head
    send_word(cdq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    send_word(cdq_pkg::CMD_PUSH_REAR, 32'h7fff_ffff);
    send_word(cdq_pkg::CMD_PUSH_FRONT, 32'hffff_ffff);
    send_word(cdq_pkg::CMD_PUSH_REAR, 32'h0000_0000);
    send_word(cdq_pkg::CMD_PUSH_REAR, 32'h0000_0001);
    send_word(cdq_pkg::CMD_PUSH_FRONT, 32'haaaa_5555);
    send_word(cdq_pkg::CMD_PUSH_REAR, 32'h5555_aaaa);
    send_word(cdq_pkg::CMD_PUSH_FRONT, $urandom);
    // pushes on a full deque are rejected
    send_word(cdq_pkg::CMD_PUSH_REAR, 32'hdead_beef);
    send_word(cdq_pkg::CMD_PUSH_FRONT, 32'hcafe_f00d);
    // drain from both ends, then one more on empty
    send_word(cdq_pkg::CMD_POP_FRONT, 32'h0);
    send_word(cdq_pkg::CMD_POP_REAR, 32'h0);
    send_word(cdq_pkg::CMD_POP_REAR, 32'h0);
    send_word(cdq_pkg::CMD_POP_FRONT, 32'h0);
    send_word(cdq_pkg::CMD_POP_FRONT, 32'h0);
    send_word(cdq_pkg::CMD_POP_REAR, 32'h0);
    send_word(cdq_pkg::CMD_POP_FRONT, 32'h0);
    send_word(cdq_pkg::CMD_POP_REAR, 32'h0);
    send_word(cdq_pkg::CMD_POP_REAR, 32'h0);

    // random runs: fill-heavy, drain-heavy or balanced, some without idling
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      span  = $urandom_range(8, 40);
      quiet = ($urandom_range(0, 4) == 0);
      case ($urandom_range(0, 2))
        0:       push_pct = 80;
        1:       push_pct = 20;
        default: push_pct = 50;
      endcase
      repeat (span) begin
        send_word(pick_command(push_pct), pick_value());
        sent++;
      end
    end
    quiet = 1'b0;
    in_valid_i <= 1'b0;

    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    if (fails == 0 && pending == 0) begin
      $display("circular_deque_unit: match");
    end else begin
      $display("circular_deque_unit: mismatch");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("circular_deque_unit: mismatch");
    $finish;
  end

endmodule
